FILE: rtl/qodm_pkg.sv
// Shared types and constants for the queue occupancy and delay monitor.
package qodm_pkg;

  localparam int unsigned ACT_W      = 2;
  localparam int unsigned TIME_IN_W  = 48;
  localparam int unsigned OCC_W      = 11;
  localparam int unsigned LIM_W      = 11;
  localparam int unsigned CNT_W32    = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 352;
  localparam int unsigned M_TUSER_W  = 3;

  // event kinds on the input tuser
  localparam logic [ACT_W-1:0] ACT_ARRIVE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEPART  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CAP_EN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_QLIMIT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WARMUP = 2'd2;

  localparam logic [LIM_W-1:0] QLIMIT_RST = 11'd1024;

  // push/pop request from the update stage to the arrival-time FIFO
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage

FILE: rtl/qodm_arrival_fifo.sv
// Arrival-time FIFO: circular memory with head/tail pointers and a registered head read.
module qodm_arrival_fifo
  import qodm_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 1024,
  parameter int unsigned TW         = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fifo_ctl_t     ctl_i,
  input  logic [TW-1:0] wdata_i,
  output logic [TW-1:0] head_time_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);

  logic [TW-1:0]    mem [FIFO_DEPTH];
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [TW-1:0]    rd_q;
  logic             fwd_q;
  logic [TW-1:0]    fwd_data_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctl_i.pop) begin
      head_d = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
    end
    if (ctl_i.push) begin
      tail_d = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fwd_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      // a write landing on the slot read this cycle is forwarded
      fwd_q  <= ctl_i.push && (tail_q == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q       <= mem[head_d];
    fwd_data_q <= wdata_i;
  end

  assign head_time_o = fwd_q ? fwd_data_q : rd_q;

endmodule

FILE: rtl/queue_occupancy_delay_monitor.sv
// Top level of the single-server queue occupancy and delay monitor.
// Each event on the input stream (tuser = kind: arrival, departure or time
// advance; tdata = timestamp in ticks) yields exactly one result transfer that
// carries the event flags, the served customer's delay, the occupancy after the
// event and running snapshots of the waiting-time and busy-time integrals, the
// delay sum and the served/counted/dropped totals. The block takes one event
// per clock while the result stream is not stalled; an event passes four
// registers (input register, state update with FIFO access, multiplier
// register, integral accumulate into the output register). Throughput is set
// by the queue state update loop and by the single read and write port of the
// arrival-time memory. Arrivals are dropped when the system holds FIFO_DEPTH
// customers or, with the capacity limit enabled, queue_limit customers. Only
// the low TIME_BITS bits of the timestamp are used; negative time steps count
// as zero elapsed ticks.
// Write configuration only while no events are in flight.
module queue_occupancy_delay_monitor
  import qodm_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 1024,
  parameter int unsigned TIME_BITS  = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // event stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [47:0] event_time
  input  logic [ACT_W-1:0]      s_axis_tuser,  // [1:0] action
  // result stream out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [47:0] delay, [58:48] occupancy, [122:59] queue_area, [186:123] busy_area,
  // [250:187] delay_total, [282:251] served_count, [314:283] counted_count,
  // [346:315] drop_count, [351:347] zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // [0] accepted, [1] was_dropped, [2] counted
  output logic [M_TUSER_W-1:0]  m_axis_tuser
);

  localparam int unsigned TW   = (TIME_BITS < TIME_IN_W) ? TIME_BITS : TIME_IN_W;
  localparam int unsigned CW   = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned LW   = (CW > LIM_W) ? CW : LIM_W;
  localparam int unsigned PW   = CW + TW;
  localparam int unsigned DLY_W = 48;
  localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

  // ---------------- configuration ----------------
  logic             cap_en_q;
  logic [LIM_W-1:0] qlimit_q;
  logic [31:0]      warmup_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_en_q <= 1'b0;
      qlimit_q <= QLIMIT_RST;
      warmup_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_CAP_EN: cap_en_q <= cfg_data_i[0];
        CFG_QLIMIT: qlimit_q <= cfg_data_i[LIM_W-1:0];
        CFG_WARMUP: warmup_q <= cfg_data_i;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  // Each stage moves forward when the next one is empty or moving; bubbles
  // collapse, so a waiting result blocks new events only once every stage
  // behind it is full.
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdyo;
  logic adv1, adv2, adv3;

  assign rdyo = ~vo_q | m_axis_tready;
  assign adv3 = v3_q & rdyo;
  assign rdy3 = ~v3_q | rdyo;
  assign adv2 = v2_q & rdy3;
  assign rdy2 = ~v2_q | rdy3;
  assign adv1 = v1_q & rdy2;
  assign rdy1 = ~v1_q | rdy2;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic [ACT_W-1:0] act1_q;
  logic [TW-1:0]    time1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      act1_q  <= s_axis_tuser;
      time1_q <= s_axis_tdata[TW-1:0];
    end
  end

  // ---------------- stage 1 -> 2: queue state update ----------------
  logic [CW-1:0] in_sys_q, in_sys_d;
  logic [TW-1:0] last_q;
  logic [31:0]   served_q, served_d, cntd_q, cntd_d, drop_q, drop_d;
  logic [31:0]   served_inc;
  logic [TW-1:0] dt, head_time, dly;
  logic [CW-1:0] nwait;
  logic          busy, full, push, pop, acc, drp, cnt;
  fifo_ctl_t     fifo_ctl;

  assign busy       = (in_sys_q != '0);
  assign nwait      = busy ? in_sys_q - 1'b1 : '0;
  assign dt         = (time1_q >= last_q) ? time1_q - last_q : '0;
  assign full       = (in_sys_q >= DEPTH_C) ||
                      (cap_en_q && (LW'(in_sys_q) >= LW'(qlimit_q)));
  assign served_inc = served_q + 32'd1;

  always_comb begin
    push = 1'b0;
    pop  = 1'b0;
    drp  = 1'b0;
    unique case (act1_q)
      ACT_ARRIVE: begin
        push = ~full;
        drp  = full;
      end
      ACT_DEPART: begin
        pop = busy;
      end
      default: ;  // time advance only, unused code included
    endcase
    acc = push | pop;
    cnt = pop && (served_inc > warmup_q);
    dly = (pop && (time1_q >= head_time)) ? time1_q - head_time : '0;

    in_sys_d = in_sys_q;
    if (push) in_sys_d = in_sys_q + 1'b1;
    if (pop)  in_sys_d = in_sys_q - 1'b1;
    served_d = pop ? served_inc : served_q;
    cntd_d   = cnt ? cntd_q + 32'd1 : cntd_q;
    drop_d   = drp ? drop_q + 32'd1 : drop_q;
  end

  assign fifo_ctl = '{push: adv1 & push, pop: adv1 & pop};

  qodm_arrival_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .TW         (TW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (fifo_ctl),
    .wdata_i     (time1_q),
    .head_time_o (head_time)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sys_q <= '0;
      last_q   <= '0;
      served_q <= '0;
      cntd_q   <= '0;
      drop_q   <= '0;
    end else if (adv1) begin
      in_sys_q <= in_sys_d;
      last_q   <= time1_q;
      served_q <= served_d;
      cntd_q   <= cntd_d;
      drop_q   <= drop_d;
    end
  end

  // stage 2 payload
  logic          acc2_q, drp2_q, cnt2_q, busy2_q;
  logic [TW-1:0] dly2_q, dt2_q;
  logic [CW-1:0] nwait2_q, occ2_q;
  logic [31:0]   served2_q, cntd2_q, drop2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      acc2_q    <= acc;
      drp2_q    <= drp;
      cnt2_q    <= cnt;
      busy2_q   <= busy;
      dly2_q    <= dly;
      dt2_q     <= dt;
      nwait2_q  <= nwait;
      occ2_q    <= in_sys_d;
      served2_q <= served_d;
      cntd2_q   <= cntd_d;
      drop2_q   <= drop_d;
    end
  end

  // ---------------- stage 2 -> 3: multiply, busy and delay sums ----------------
  logic [ACC_W-1:0] busy_acc_q, busy_acc_d, dsum_q, dsum_d;

  assign busy_acc_d = busy2_q ? busy_acc_q + ACC_W'(dt2_q) : busy_acc_q;
  assign dsum_d     = cnt2_q ? dsum_q + ACC_W'(dly2_q) : dsum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_acc_q <= '0;
      dsum_q     <= '0;
    end else if (adv2) begin
      busy_acc_q <= busy_acc_d;
      dsum_q     <= dsum_d;
    end
  end

  logic             acc3_q, drp3_q, cnt3_q;
  logic [TW-1:0]    dly3_q;
  logic [CW-1:0]    occ3_q;
  logic [PW-1:0]    prod3_q;
  logic [ACC_W-1:0] busy3_q, dsum3_q;
  logic [31:0]      served3_q, cntd3_q, drop3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      acc3_q    <= acc2_q;
      drp3_q    <= drp2_q;
      cnt3_q    <= cnt2_q;
      dly3_q    <= dly2_q;
      occ3_q    <= occ2_q;
      prod3_q   <= PW'(nwait2_q) * PW'(dt2_q);
      busy3_q   <= busy_acc_d;
      dsum3_q   <= dsum_d;
      served3_q <= served2_q;
      cntd3_q   <= cntd2_q;
      drop3_q   <= drop2_q;
    end
  end

  // ---------------- stage 3 -> out: waiting-time integral ----------------
  logic [ACC_W-1:0] wait_acc_q, wait_acc_d;

  assign wait_acc_d = wait_acc_q + ACC_W'(prod3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_acc_q <= '0;
    end else if (adv3) begin
      wait_acc_q <= wait_acc_d;
    end
  end

  logic [M_TDATA_W-1:0] tdata_q;
  logic [M_TUSER_W-1:0] tuser_q;

  always_ff @(posedge clk_i) begin
    if (rdyo) begin
      tuser_q <= {cnt3_q, drp3_q, acc3_q};
      tdata_q <= {5'd0, drop3_q, cntd3_q, served3_q, dsum3_q, busy3_q, wait_acc_d,
                  OCC_W'(occ3_q), DLY_W'(dly3_q)};
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  // ---------------- assertions ----------------
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sys_q <= DEPTH_C)
    else $error("customer count above FIFO depth");

  a_depart_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv1 && act1_q == ACT_DEPART) |=> (in_sys_q <= $past(in_sys_q)))
    else $error("departure raised the customer count");

  a_flags_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!(m_axis_tuser[0] && m_axis_tuser[1]) &&
                       (!m_axis_tuser[2] || m_axis_tuser[0])))
    else $error("inconsistent result flags");

  a_push_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_ctl.push |-> (in_sys_q < DEPTH_C) && !fifo_ctl.pop)
    else $error("FIFO push while full or together with pop");

endmodule

FILE: test/queue_occupancy_delay_monitor_test.sv
// Self-checking testbench for the queue occupancy and delay monitor.
module queue_occupancy_delay_monitor_test;
  import qodm_pkg::*;

  // Action code 3 has no name in the package; the block treats it as a time advance.
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned GAP_MAX      = 18;    // longest sender gap / receiver stall
  localparam int unsigned IDLE_LIMIT   = 4000;  // cycles without any transfer
  localparam int unsigned DRAIN_CYCLES = 16;    // settle time after last result
  localparam int unsigned MAX_PRINTS   = 40;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 20;
  localparam int unsigned FILL_ITEMS   = 1030;  // arrivals only: overruns the FIFO
  localparam int unsigned TRIM_ITEMS   = 40;    // mixed traffic around the full point
  localparam logic [TIME_IN_W-1:0] T_MAX = '1;

  typedef enum logic [1:0] {OP_EVENT, OP_CFG, OP_DRAIN} op_kind_e;

  // One entry of the stimulus script: an event, a register write or a pause
  // that holds the sender until every expected result has come back.
  typedef struct {
    op_kind_e              kind;
    logic [ACT_W-1:0]      act;
    logic [TIME_IN_W-1:0]  stamp;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
  } script_op_t;

  // Expected content of one result transfer.
  typedef struct packed {
    logic                 accepted;
    logic                 dropped;
    logic                 counted;
    logic [TIME_IN_W-1:0] delay;
    logic [OCC_W-1:0]     occupancy;
    logic [ACC_W-1:0]     queue_area;
    logic [ACC_W-1:0]     busy_area;
    logic [ACC_W-1:0]     delay_total;
    logic [CNT_W32-1:0]   served;
    logic [CNT_W32-1:0]   counted_n;
    logic [CNT_W32-1:0]   drops;
  } snapshot_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // [47:0] event_time
  logic [ACT_W-1:0]      s_axis_tuser  = '0;  // [1:0] action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [47:0] delay, [58:48] occupancy, [122:59] queue_area, [186:123] busy_area,
  // [250:187] delay_total, [282:251] served_count, [314:283] counted_count,
  // [346:315] drop_count, [351:347] zero
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;        // [0] accepted, [1] was_dropped, [2] counted

  queue_occupancy_delay_monitor #(
    .FIFO_DEPTH(DEPTH),
    .TIME_BITS (TIME_IN_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Queue statistics predictor: own copy of config and state
  // ---------------------------------------------------------------------------
  logic                 cap_en_m    = 1'b0;
  logic [LIM_W-1:0]     limit_m     = QLIMIT_RST;
  logic [CNT_W32-1:0]   warmup_m    = '0;
  logic [OCC_W-1:0]     occ_m       = '0;
  logic [TIME_IN_W-1:0] last_m      = '0;
  logic [TIME_IN_W-1:0] arrival_m [DEPTH];
  logic [9:0]           head_m      = '0;   // wraps at DEPTH naturally
  logic [9:0]           tail_m      = '0;
  logic [ACC_W-1:0]     wait_area_m = '0;
  logic [ACC_W-1:0]     busy_area_m = '0;
  logic [ACC_W-1:0]     delay_sum_m = '0;
  logic [CNT_W32-1:0]   served_m    = '0;
  logic [CNT_W32-1:0]   counted_m   = '0;
  logic [CNT_W32-1:0]   dropped_m   = '0;

  // Testbench bookkeeping
  script_op_t  event_script[$];       // stimulus not yet handed to the DUT
  snapshot_t   pending_snapshots[$];  // results owed by the DUT, oldest first
  int unsigned mismatches  = 0;
  int unsigned result_no   = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  bit          send_calm   = 1'b0;
  bit          rcv_calm    = 1'b0;
  bit          ev_fire     = 1'b0;    // handshakes seen at the last rising edge
  bit          cfg_fire    = 1'b0;
  bit          res_fire    = 1'b0;
  logic [TIME_IN_W-1:0] stamp_now = '0;

  function automatic void apply_config(logic [CFG_ADDR_W-1:0] addr,
                                       logic [CFG_DATA_W-1:0] data);
    case (addr)
      CFG_CAP_EN: cap_en_m = data[0];
      CFG_QLIMIT: limit_m  = data[LIM_W-1:0];
      CFG_WARMUP: warmup_m = data;
      default: ;
    endcase
  endfunction

  // Advance the integrals to the event time, then apply the event.
  function automatic snapshot_t serve_event(logic [ACT_W-1:0] act,
                                            logic [TIME_IN_W-1:0] now);
    snapshot_t            r;
    logic [TIME_IN_W-1:0] dt;
    logic [TIME_IN_W-1:0] arrived;
    r  = '0;
    // backward time steps add nothing but still move the time base
    dt = (now >= last_m) ? now - last_m : '0;
    if (occ_m != '0) begin
      wait_area_m += ACC_W'(occ_m - 1'b1) * ACC_W'(dt);
      busy_area_m += ACC_W'(dt);
    end
    last_m = now;
    if (act == ACT_ARRIVE) begin
      // full at FIFO depth, or at the limit when capacity is enabled
      if (occ_m >= OCC_W'(DEPTH) || (cap_en_m && occ_m >= limit_m)) begin
        r.dropped = 1'b1;
        dropped_m++;
      end else begin
        arrival_m[tail_m] = now;
        tail_m++;
        occ_m++;
        r.accepted = 1'b1;
      end
    end else if (act == ACT_DEPART && occ_m != '0) begin
      arrived = arrival_m[head_m];
      head_m++;
      occ_m--;
      r.accepted = 1'b1;
      served_m++;
      // departure stamped before its arrival gives zero delay
      r.delay = (now >= arrived) ? now - arrived : '0;
      if (served_m > warmup_m) begin
        r.counted = 1'b1;
        counted_m++;
        delay_sum_m += ACC_W'(r.delay);
      end
    end
    r.occupancy   = occ_m;
    r.queue_area  = wait_area_m;
    r.busy_area   = busy_area_m;
    r.delay_total = delay_sum_m;
    r.served      = served_m;
    r.counted_n   = counted_m;
    r.drops       = dropped_m;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH %0s", msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %0s: got %0h want %0h",
                                result_no, name, got, want));
  endtask

  task automatic check_result(snapshot_t want);
    check_field("accepted",      64'(m_axis_tuser[0]),        64'(want.accepted));
    check_field("was_dropped",   64'(m_axis_tuser[1]),        64'(want.dropped));
    check_field("counted",       64'(m_axis_tuser[2]),        64'(want.counted));
    check_field("delay",         64'(m_axis_tdata[47:0]),     64'(want.delay));
    check_field("occupancy",     64'(m_axis_tdata[58:48]),    64'(want.occupancy));
    check_field("queue_area",    m_axis_tdata[122:59],        want.queue_area);
    check_field("busy_area",     m_axis_tdata[186:123],       want.busy_area);
    check_field("delay_total",   m_axis_tdata[250:187],       want.delay_total);
    check_field("served_count",  64'(m_axis_tdata[282:251]),  64'(want.served));
    check_field("counted_count", 64'(m_axis_tdata[314:283]),  64'(want.counted_n));
    check_field("drop_count",    64'(m_axis_tdata[346:315]),  64'(want.drops));
    check_field("tdata pad",     64'(m_axis_tdata[351:347]),  64'd0);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. Accepted events feed
  // the predictor in transfer order; accepted results are checked against
  // the oldest expectation. A watchdog ends the run if the DUT goes quiet.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ev_fire  = s_axis_tvalid && s_axis_tready;
    cfg_fire = cfg_valid_i && cfg_ready_o;
    res_fire = m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (cfg_fire) apply_config(cfg_addr_i, cfg_data_i);
      if (ev_fire)
        pending_snapshots.insert(pending_snapshots.size(),
                                 serve_event(s_axis_tuser, s_axis_tdata));
      if (res_fire) begin
        if (pending_snapshots.size() == 0)
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_no));
        else
          check_result(pending_snapshots.pop_front());
        result_no++;
      end
      if (ev_fire || cfg_fire || res_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: runs at the falling edge, works down the script. After each event
  // it draws a random gap of at most GAP_MAX, with calm stretches of no gaps.
  // Register writes and pauses wait until no result is outstanding, so the
  // configuration only changes while the DUT is idle.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ev_fire) s_axis_tvalid = 1'b0;
      if (cfg_fire) cfg_valid_i = 1'b0;
      if (!s_axis_tvalid && !cfg_valid_i) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (event_script.size() > 0) begin
          case (event_script[0].kind)
            OP_EVENT: begin
              s_axis_tuser  = event_script[0].act;
              s_axis_tdata  = event_script[0].stamp;
              s_axis_tvalid = 1'b1;
              void'(event_script.pop_front());
              send_gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
              if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
            end
            OP_CFG: begin
              if (pending_snapshots.size() == 0) begin
                cfg_addr_i  = event_script[0].addr;
                cfg_data_i  = event_script[0].data;
                cfg_valid_i = 1'b1;
                void'(event_script.pop_front());
              end
            end
            default: begin
              if (pending_snapshots.size() == 0) void'(event_script.pop_front());
            end
          endcase
        end
      end
    end
  end

  // Receiver: after every result transfer, hold tready low for a random stall
  // of at most GAP_MAX; calm stretches keep it high.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_fire) begin
        stall_left = rcv_calm ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 79) == 0) rcv_calm = !rcv_calm;
      end
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Script building
  // ---------------------------------------------------------------------------
  task automatic add_event(logic [ACT_W-1:0] act, logic [TIME_IN_W-1:0] stamp);
    script_op_t o;
    o.kind  = OP_EVENT;
    o.act   = act;
    o.stamp = stamp;
    o.addr  = '0;
    o.data  = '0;
    event_script.insert(event_script.size(), o);
  endtask

  task automatic add_cfg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    script_op_t o;
    o.kind  = OP_CFG;
    o.act   = ACT_ADVANCE;
    o.stamp = '0;
    o.addr  = addr;
    o.data  = data;
    event_script.insert(event_script.size(), o);
  endtask

  task automatic add_drain();
    script_op_t o;
    o.kind  = OP_DRAIN;
    o.act   = ACT_ADVANCE;
    o.stamp = '0;
    o.addr  = '0;
    o.data  = '0;
    event_script.insert(event_script.size(), o);
  endtask

  // Mostly small forward steps; sometimes time runs backward, jumps to a
  // random 48-bit value or lands just below the top of the range.
  function automatic logic [TIME_IN_W-1:0] next_stamp(logic [TIME_IN_W-1:0] cur);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return cur - TIME_IN_W'($urandom_range(1, 500));
    if (pick < 7) return TIME_IN_W'({$urandom, $urandom});
    if (pick < 9) return T_MAX - TIME_IN_W'($urandom_range(0, 50));
    return cur + TIME_IN_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [ACT_W-1:0] random_action();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 46) return ACT_ARRIVE;
    if (pick < 88) return ACT_DEPART;
    if (pick < 95) return ACT_ADVANCE;
    return ACT_SPARE;
  endfunction

  initial begin
    int unsigned drain_at;

    // --- directed: default config (capacity off, warmup 0) ---
    add_event(ACT_DEPART,  48'd0);   // departure from an empty system is ignored
    add_event(ACT_ADVANCE, 48'd0);
    add_event(ACT_ARRIVE,  48'd5);
    add_event(ACT_ARRIVE,  48'd5);
    add_event(ACT_ARRIVE,  48'd10);
    add_event(ACT_ADVANCE, 48'd20);
    add_event(ACT_DEPART,  48'd30);  // delay 25
    add_event(ACT_DEPART,  48'd25);  // time runs backward: no area added
    add_event(ACT_SPARE,   48'd40);  // unused code acts as a time advance
    add_event(ACT_DEPART,  48'd3);   // served before its arrival: zero delay
    add_event(ACT_ARRIVE,  T_MAX);
    add_event(ACT_DEPART,  T_MAX);
    add_event(ACT_ARRIVE,  48'd0);
    add_event(ACT_DEPART,  T_MAX);   // largest delay
    // capacity limit of zero drops every arrival
    add_cfg(CFG_CAP_EN, 32'd1);
    add_cfg(CFG_QLIMIT, 32'd0);
    add_event(ACT_ARRIVE,  48'd100);
    // limit of two: third arrival dropped
    add_cfg(CFG_QLIMIT, 32'd2);
    add_event(ACT_ARRIVE,  48'd110);
    add_event(ACT_ARRIVE,  48'd120);
    add_event(ACT_ARRIVE,  48'd130);
    // five served so far: a warmup of six keeps the next one out of the stats
    add_cfg(CFG_WARMUP, 32'd6);
    add_event(ACT_DEPART,  48'd140);
    add_event(ACT_DEPART,  48'd150);
    stamp_now = 48'd150;

    // --- random phases, each under its own setting ---
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          add_cfg(CFG_CAP_EN, 32'd1);
          add_cfg(CFG_QLIMIT, 32'd1);
          add_cfg(CFG_WARMUP, 32'd0);
        end
        1: begin
          add_cfg(CFG_QLIMIT, 32'(QLIMIT_RST));
          add_cfg(CFG_WARMUP, 32'hFFFF_FFFF);  // nothing ever counted
        end
        2: begin
          add_cfg(CFG_CAP_EN, 32'd0);          // limit of zero is ignored
          add_cfg(CFG_QLIMIT, 32'd0);
          add_cfg(CFG_WARMUP, 32'd0);
        end
        default: begin
          add_cfg(CFG_CAP_EN, 32'($urandom_range(0, 1)));
          add_cfg(CFG_QLIMIT, ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 8))
                                                          : 32'($urandom_range(0, DEPTH)));
          add_cfg(CFG_WARMUP, 32'($urandom_range(0, 300)));
        end
      endcase
      drain_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (i == drain_at) add_drain();  // sender waits for all results
        stamp_now = next_stamp(stamp_now);
        add_event(random_action(), stamp_now);
      end
    end

    // --- fill past the FIFO depth with capacity off, then work around full ---
    add_cfg(CFG_CAP_EN, 32'd0);
    add_cfg(CFG_WARMUP, 32'($urandom_range(0, 20)));
    for (int unsigned i = 0; i < FILL_ITEMS; i++) begin
      stamp_now = stamp_now + TIME_IN_W'($urandom_range(0, 3));
      add_event(ACT_ARRIVE, stamp_now);
    end
    for (int unsigned i = 0; i < TRIM_ITEMS; i++) begin
      stamp_now = stamp_now + TIME_IN_W'($urandom_range(0, 3));
      add_event(($urandom_range(0, 2) == 0) ? ACT_ARRIVE : ACT_DEPART, stamp_now);
    end

    // single reset at the start, released between clock edges
    repeat (8) @(posedge clk_i);
    #1 rst_ni = 1'b1;

    // wait for the script and every owed result, then let the pipe settle
    while (event_script.size() != 0 || s_axis_tvalid || cfg_valid_i ||
           pending_snapshots.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending_snapshots.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_snapshots.size()));

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
